/* design/roulette_wheel_selector_unit_macros.svh */
// ----------------------------------------------------------------------------
// Roulette wheel selector assertion macros
// Shared assertion forms for the selector; they expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_SELECTOR_UNIT_MACROS_SVH
`define ROULETTE_WHEEL_SELECTOR_UNIT_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define RWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define RWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rws_pkg.sv */
// ----------------------------------------------------------------------------
// Roulette wheel selector package
// Widths, codes and the command and status bundles shared by the selector.
// ----------------------------------------------------------------------------
package rws_pkg;

  // Table size and fixed point scaling of the random fraction.
  localparam int MAX_MEMBERS   = 256;
  localparam int FRACTION_BITS = 16;

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int ID_W    = 8;
  localparam int FIT_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int TOT_W   = 24;
  localparam int IDX_W   = $clog2(MAX_MEMBERS);
  localparam int CNT_W   = $clog2(MAX_MEMBERS + 1);
  localparam int ENTRY_W = ID_W + TOT_W;
  localparam int PROD_W  = FRAC_W + TOT_W;

  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  // Item operation codes; the fourth code is unused and ignored.
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_SELECT = 2'd2
  } rws_mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PROBE,
    ST_CMP,
    ST_FETCH,
    ST_DONE
  } rws_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // empty the table
    logic load;      // append the incoming member
    logic capture;   // latch the random fraction of a select
    logic start_mul; // form the scaled product and open the search window
    logic probe;     // issue a read at the window midpoint
    logic compare;   // narrow the window with the probed total
    logic fetch;     // latch the identifier of the chosen slot
    logic set_err;   // latch an error result
    logic out_load;  // move the result into the output register
  } rws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_wheel;    // table empty or total fitness zero
    logic search_done; // window has closed on one slot
    logic out_free;    // output register can take a word this cycle
  } rws_stat_t;

endpackage

/* design/rws_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/rws_ctrl.sv */
// ----------------------------------------------------------------------------
// Roulette wheel selector controller
// Sequences clear, load and select items and the binary search probes.
// ----------------------------------------------------------------------------
module rws_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [rws_pkg::MODE_W-1:0]  mode,
  input  rws_pkg::rws_stat_t          stat,
  output logic                        in_stall,
  output rws_pkg::rws_cmd_t           cmd
);

  import rws_pkg::*;

  rws_state_t state;
  rws_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Items are taken only while no select is in flight.
  assign in_stall = (state != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (rws_mode_t'(mode))
            MODE_CLEAR: begin
              cmd.clear = 1'b1;
            end
            MODE_LOAD: begin
              cmd.load = 1'b1;
            end
            MODE_SELECT: begin
              if (stat.no_wheel) begin
                cmd.set_err = 1'b1;
                state_next  = ST_DONE;
              end else begin
                cmd.capture = 1'b1;
                state_next  = ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        cmd.start_mul = 1'b1;
        state_next    = ST_PROBE;
      end
      ST_PROBE: begin
        cmd.probe  = 1'b1;
        state_next = stat.search_done ? ST_FETCH : ST_CMP;
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = ST_PROBE;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/rws_dp.sv */
// ----------------------------------------------------------------------------
// Roulette wheel selector datapath
// Member table, running total, scaled target, search window and output word.
// ----------------------------------------------------------------------------
module rws_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  rws_pkg::rws_cmd_t           cmd,
  input  logic [rws_pkg::ID_W-1:0]    member_id,
  input  logic [rws_pkg::FIT_W-1:0]   fitness,
  input  logic [rws_pkg::FRAC_W-1:0]  random_fraction,
  input  logic                        out_stall,
  output rws_pkg::rws_stat_t          stat,
  output logic                        out_valid,
  output logic [rws_pkg::ID_W-1:0]    selected_id,
  output logic                        error
);

  import rws_pkg::*;

  logic [CNT_W-1:0]   count;
  logic [TOT_W-1:0]   total;
  logic [FRAC_W-1:0]  frac;
  logic [PROD_W-1:0]  prod;
  logic [IDX_W-1:0]   lo;
  logic [IDX_W-1:0]   hi;
  logic [IDX_W-1:0]   mid;
  logic [IDX_W-1:0]   mid_r;
  logic [ID_W-1:0]    sel_id;
  logic               sel_err;

  logic               full;
  logic [TOT_W:0]     sum;
  logic [TOT_W-1:0]   total_next;
  logic [CNT_W-1:0]   count_m1;
  logic [PROD_W-1:0]  scaled;
  logic [TOT_W-1:0]   target;
  logic               we;
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;

  // Saturating running total for a load.
  assign full       = (count == CNT_W'(MAX_MEMBERS));
  assign sum        = {1'b0, total} + (TOT_W + 1)'(fitness);
  assign total_next = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
  assign count_m1   = count - CNT_W'(1);

  // Target is the product scaled down by the fraction width, clamped to the total range.
  assign scaled = prod >> FRACTION_BITS;
  assign target = (scaled > PROD_W'(TOTAL_MAX)) ? TOTAL_MAX : scaled[TOT_W-1:0];

  // Search window midpoint; the closed window reads its last slot.
  assign mid   = lo + ((hi - lo) >> 1);
  assign raddr = (lo < hi) ? mid : lo;
  assign we    = cmd.load && !full;

  // Table entries hold the identifier over the cumulative total.
  rws_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_MEMBERS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({member_id, total_next}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Member count and running total.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      total <= '0;
    end else if (we) begin
      count <= count + CNT_W'(1);
      total <= total_next;
    end
  end

  // Fraction capture, product and search window.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frac <= random_fraction;
    end
    if (cmd.start_mul) begin
      prod <= PROD_W'(frac) * PROD_W'(total);
      lo   <= '0;
      hi   <= count_m1[IDX_W-1:0];
    end
    if (cmd.probe) begin
      mid_r <= mid;
    end
    if (cmd.compare) begin
      if (rdata[TOT_W-1:0] > target) begin
        hi <= mid_r;
      end else begin
        lo <= mid_r + IDX_W'(1);
      end
    end
  end

  // Result held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      sel_id  <= rdata[ENTRY_W-1:TOT_W];
      sel_err <= 1'b0;
    end else if (cmd.set_err) begin
      sel_id  <= '0;
      sel_err <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      selected_id <= sel_id;
      error       <= sel_err;
    end
  end

  // Status for the controller.
  assign stat.no_wheel    = (count == '0) || (total == '0);
  assign stat.search_done = !(lo < hi);
  assign stat.out_free    = !out_valid || !out_stall;

endmodule

/* design/roulette_wheel_selector_unit.sv */
// ----------------------------------------------------------------------------
// Roulette wheel selector unit
// Fitness-proportionate selection over a table of loaded members.
// ----------------------------------------------------------------------------
// A clear or load word is followed at once by the next word. A select word
// captures the random fraction and, in the multiply state, scales the running
// total by it. It then binary searches the cumulative totals, which are held
// in a table RAM with one registered read port. Each probe reads the window
// midpoint, then narrows the window. After the search, a final probe reads the
// chosen slot, the fetch state latches its identifier and the done state hands
// the result over. The input stalls while a select is in flight. A select on
// an empty table or a zero total goes straight to the done state and returns
// error with identifier zero. The result waits in an output register, and the
// unit keeps taking words while it waits. A select that finishes while an
// earlier result is still held keeps the input stalled until that result is
// taken.
`include "roulette_wheel_selector_unit_macros.svh"

module roulette_wheel_selector_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rws_pkg::MODE_W-1:0]  mode,
  input  logic [rws_pkg::ID_W-1:0]    member_id,
  input  logic [rws_pkg::FIT_W-1:0]   fitness,
  input  logic [rws_pkg::FRAC_W-1:0]  random_fraction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rws_pkg::ID_W-1:0]    selected_id,
  output logic                        error
);

  import rws_pkg::*;

  rws_cmd_t  cmd;
  rws_stat_t stat;
  logic      sel_accept;

  // Controller.
  rws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Datapath.
  rws_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .member_id       (member_id),
    .fitness         (fitness),
    .random_fraction (random_fraction),
    .out_stall       (out_stall),
    .stat            (stat),
    .out_valid       (out_valid),
    .selected_id     (selected_id),
    .error           (error)
  );

  assign sel_accept = in_valid && !in_stall && (mode == MODE_SELECT);

  // Checks.
  `RWS_ASSERT_NEXT(a_select_busy, sel_accept, in_stall, "select word did not hold off input")
  `RWS_ASSERT_SAME(a_rise_from_load, $rose(out_valid), $past(cmd.out_load), "result without load")
  `RWS_ASSERT_SAME(a_err_id_zero, out_valid && error, selected_id == '0, "error with nonzero id")
  `RWS_ASSERT_SAME(a_table_idle, cmd.load || cmd.clear, !in_stall, "table change while busy")

endmodule
